@@ design/timed_pulse_output_bank_defines.svh @@
// Assertion macros shared by the timed pulse output bank RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef TIMED_PULSE_OUTPUT_BANK_DEFINES_SVH
`define TIMED_PULSE_OUTPUT_BANK_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define TPOB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante.
`define TPOB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tpob_pkg.sv @@
// Package for the timed pulse output bank: field widths, command codes and
// the request, response and per-line command types. No dependencies.
`timescale 1ns / 1ps

package tpob_pkg;

    localparam int OP_W            = 3;
    localparam int CHANNEL_W       = 5;
    localparam int TIMER_W         = 16;
    localparam int VEC_W           = 16;
    localparam int NUM_OUTPUTS_DEF = 16;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_SET     = 3'd1,
        OP_TOGGLE  = 3'd2,
        OP_PULSE   = 3'd3,
        OP_ALL_OFF = 3'd4
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [CHANNEL_W-1:0] channel;
        logic                 level;
        logic [TIMER_W-1:0]   duration;
    } req_t;

    typedef struct packed {
        logic [VEC_W-1:0] output_levels;
        logic [VEC_W-1:0] busy_mask;
        logic             channel_level;
    } rsp_t;

    // Command broadcast to every line; hit is supplied per line.
    typedef struct packed {
        logic               en;
        op_t                op;
        logic               level;
        logic [TIMER_W-1:0] duration;
    } cell_cmd_t;

    // Line state as it will be after the command in flight.
    typedef struct packed {
        logic level;
        logic busy;
    } cell_stat_t;

endpackage

@@ design/tpob_cell.sv @@
// One output line of the bank: a level bit and a pulse timer.
// Depends on tpob_pkg for the command and status types.
`timescale 1ns / 1ps

module tpob_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tpob_pkg::cell_cmd_t  cmd,
    input  logic                 hit,
    output tpob_pkg::cell_stat_t stat
);

    logic                         level_reg;
    logic                         level_next;
    logic [tpob_pkg::TIMER_W-1:0] timer_reg;
    logic [tpob_pkg::TIMER_W-1:0] timer_next;
    logic                         timer_idle;

    assign timer_idle = (timer_reg == '0);

    always_comb
    begin
        level_next = level_reg;
        timer_next = timer_reg;
        if (cmd.en)
        begin
            case (cmd.op)
                tpob_pkg::OP_TICK:
                begin
                    if (!timer_idle)
                    begin
                        timer_next = timer_reg - tpob_pkg::TIMER_W'(1);
                        // The line flips on the tick that empties its timer.
                        if (timer_reg == tpob_pkg::TIMER_W'(1))
                        begin
                            level_next = ~level_reg;
                        end
                    end
                end
                tpob_pkg::OP_SET:
                begin
                    if (hit)
                    begin
                        level_next = cmd.level;
                        timer_next = '0;
                    end
                end
                tpob_pkg::OP_TOGGLE:
                begin
                    if (hit)
                    begin
                        level_next = ~level_reg;
                        timer_next = '0;
                    end
                end
                tpob_pkg::OP_PULSE:
                begin
                    // A running pulse is reloaded with the new duration, never flipped twice.
                    if (hit && (cmd.duration != '0))
                    begin
                        if (timer_idle)
                        begin
                            level_next = ~level_reg;
                        end
                        timer_next = cmd.duration;
                    end
                end
                tpob_pkg::OP_ALL_OFF:
                begin
                    level_next = 1'b0;
                    timer_next = '0;
                end
                default:
                begin
                    level_next = level_reg;
                    timer_next = timer_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            timer_reg <= '0;
        end
        else if (cmd.en)
        begin
            level_reg <= level_next;
            timer_reg <= timer_next;
        end
    end

    assign stat.level = level_next;
    assign stat.busy  = (timer_next != '0);

endmodule

@@ design/timed_pulse_output_bank.sv @@
// Timed pulse output bank: a request register, a row of line cells that
// apply the command, and a response register. An accepted request is held in
// the request register, and its result is captured in the response register.
// One request is accepted per cycle while the response side takes results.
// Reset clears every level, every timer and both valid flags.
`timescale 1ns / 1ps

`include "timed_pulse_output_bank_defines.svh"

module timed_pulse_output_bank
#(
    parameter int NUM_OUTPUTS = tpob_pkg::NUM_OUTPUTS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tpob_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tpob_pkg::rsp_t rsp
);

    logic                 req_valid_reg;
    tpob_pkg::req_t       req_reg;
    logic                 rsp_valid_reg;
    tpob_pkg::rsp_t       rsp_reg;
    tpob_pkg::rsp_t       rsp_next;
    logic                 exec_en;
    tpob_pkg::cell_cmd_t  cmd;
    tpob_pkg::cell_stat_t stat [NUM_OUTPUTS];
    logic [NUM_OUTPUTS-1:0] hit;
    logic [NUM_OUTPUTS-1:0] lvl_next;
    logic [NUM_OUTPUTS-1:0] busy_next;
    logic                 ch_level;

    // The held request executes whenever the response register can take it.
    assign exec_en   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || exec_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            req_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            req_reg <= req;
        end
    end

    assign cmd.en       = exec_en;
    assign cmd.op       = tpob_pkg::op_t'(req_reg.operation);
    assign cmd.level    = req_reg.level;
    assign cmd.duration = req_reg.duration;

    for (genvar i = 0; i < NUM_OUTPUTS; i++)
    begin : g_line
        assign hit[i] = (req_reg.channel == tpob_pkg::CHANNEL_W'(i));

        tpob_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .hit   (hit[i]),
            .stat  (stat[i])
        );

        assign lvl_next[i]  = stat[i].level;
        assign busy_next[i] = stat[i].busy;
    end

    // Lines beyond the report width are seen only through channel_level.
    for (genvar b = 0; b < tpob_pkg::VEC_W; b++)
    begin : g_vec
        if (b < NUM_OUTPUTS)
        begin : g_live
            assign rsp_next.output_levels[b] = lvl_next[b];
            assign rsp_next.busy_mask[b]     = busy_next[b];
        end
        else
        begin : g_none
            assign rsp_next.output_levels[b] = 1'b0;
            assign rsp_next.busy_mask[b]     = 1'b0;
        end
    end

    // A channel beyond the bank matches no line and reads as zero.
    always_comb
    begin
        ch_level = 1'b0;
        for (int i = 0; i < NUM_OUTPUTS; i++)
        begin
            ch_level = ch_level | (hit[i] & lvl_next[i]);
        end
    end

    assign rsp_next.channel_level = ch_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (!rsp_valid_reg || rsp_ready)
        begin
            rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `TPOB_ASSERT_NEXT(a_held_request_moves, req_valid_reg && !rsp_valid_reg, rsp_valid_reg,
        "held request did not reach the response register")
    `TPOB_ASSERT_NOW(a_ready_when_empty, !rsp_valid_reg, req_ready,
        "request side stalled while the response register was empty")
    `TPOB_ASSERT_NEXT(a_all_off_clears, exec_en && (req_reg.operation == tpob_pkg::OP_ALL_OFF),
        (rsp.output_levels == '0) && (rsp.busy_mask == '0) && !rsp.channel_level,
        "all-off left a line on or a timer running")

endmodule
